[hw/rtl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

[hw/rtl/tess_pkg.sv]
// Types and constants shared by the timed event slot scheduler modules.
`timescale 1ns / 1ps

package tess_pkg;

	localparam int TICK_W  = 48;
	localparam int DELAY_W = 27;
	localparam int FREQ_W  = 20;
	localparam int MS_W    = 16;
	localparam int PROD_W  = MS_W + FREQ_W;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd100000;

	// Millisecond conversion: x / 1000 is (x / 8) / 125, and the division by 125 is a
	// multiplication by its rounded-up reciprocal, done in two half-width passes.
	localparam int MS_PER_SEC  = 1000;
	localparam int PRE_SHIFT   = 3;
	localparam int RECIP_DIV   = MS_PER_SEC >> PRE_SHIFT;
	localparam int QDIV_W      = PROD_W - PRE_SHIFT;
	localparam int RECIP_SHIFT = QDIV_W + $clog2(RECIP_DIV);
	localparam int RECIP_W     = QDIV_W + 1;
	localparam int RECIP_HALF  = RECIP_W / 2;
	localparam int PART_W      = QDIV_W + RECIP_HALF;
	localparam int ACC_W       = QDIV_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(RECIP_DIV - 1)) / 64'(RECIP_DIV));
	localparam logic [RECIP_HALF-1:0] RECIP_LO = RECIP[RECIP_HALF-1:0];
	localparam logic [RECIP_HALF-1:0] RECIP_HI = RECIP[RECIP_W-1:RECIP_HALF];
	localparam int DIV_STEPS   = 2;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	// Request type codes.
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_CREATE = 3'd1;
	localparam logic [2:0] REQ_PAUSE  = 3'd2;
	localparam logic [2:0] REQ_RESUME = 3'd3;
	localparam logic [2:0] REQ_KILL   = 3'd4;

	// Result kind codes.
	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_FIRED   = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;
	localparam logic [1:0] KIND_NO_FIRE = 2'd3;

	typedef struct packed {
		logic [2:0]      req_type;
		logic [2:0]      slot_index;
		logic [MS_W-1:0] interval_ms;
		logic            repeat_flag;
	} tess_in_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [2:0]        result_slot;
		logic [TICK_W-1:0] next_deadline;
		logic              last_result;
	} tess_out_t;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_CREATE,
		OP_PAUSE,
		OP_RESUME,
		OP_KILL,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [2:0]         idx;
		logic [DELAY_W-1:0] delay;
		logic               rep;
	} tess_cmd_t;

	typedef enum logic [1:0] {
		FE_IDLE,
		FE_DIV,
		FE_SEND
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_IDLE,
		BE_SCAN,
		BE_DRAIN,
		BE_EMIT
	} be_state_t;

endpackage

[hw/rtl/timed_event_slot_scheduler.sv]
// Top level of the timed event slot scheduler: frequency register, front end, queue, back end.
// Each request occupies the back end for a scan through the deadline memory, one slot per cycle,
// followed by its results, which wait in the output register until taken; a create is first
// multiplied and divided in the front end.
// Reset (asynchronous, active low) frees every slot, zeroes the tick counter and loads 100000.
`timescale 1ns / 1ps

module timed_event_slot_scheduler import tess_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tess_in_t          item,
	output logic              empty,
	input  logic              pop,
	output tess_out_t         result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [FREQ_W-1:0] cfg_data
);

	// The tick frequency register. Writes are expected only while the block is
	// idle, so it is always ready and takes every transfer on its channel.
	logic [FREQ_W-1:0] tick_frequency_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_frequency_q <= FREQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tick_frequency_q <= cfg_data;
		end
	end

	// Command path from the front end to the back end. The front end decodes
	// each request and, for a create, turns the millisecond interval into a
	// delay in ticks (interval times frequency, divided by one thousand). The
	// queue lets it take the next request while the back end is still busy
	// scanning slots or waiting for its results to be taken.
	logic      cmd_push, cmd_full, cmd_pop, cmd_valid;
	tess_cmd_t cmd_in, cmd_out;

	tess_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.item           (item),
		.tick_frequency (tick_frequency_q),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in),
		.cmd_full       (cmd_full)
	);

	tess_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.valid     (cmd_valid)
	);

	// The back end owns the tick counter and the slot table. For every command
	// it walks all slots in ascending order, applying the command to the slot it
	// concerns (or, for a tick, firing every due slot), and folds the earliest
	// enabled deadline as it goes. Results then leave one per transfer through
	// an output register, each carrying that earliest deadline.
	tess_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[hw/rtl/tess_front.sv]
// Front end: takes requests, decodes them and converts create intervals to ticks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tess_front import tess_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  tess_in_t          item,
	input  logic [FREQ_W-1:0] tick_frequency,
	output logic              cmd_push,
	output tess_cmd_t         cmd,
	input  logic              cmd_full
);

	fe_state_t state_q, state_d;
	op_t op_in;
	op_t op_q;
	logic [2:0] idx_q;
	logic rep_q;
	logic [PROD_W-1:0] prod_q;
	logic [QDIV_W-1:0] quo_in;
	logic [RECIP_HALF-1:0] recip_part;
	logic [PART_W-1:0] part;
	logic [ACC_W-1:0] acc_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic accept;

	always_comb begin
		unique case (item.req_type)
			REQ_TICK:   op_in = OP_TICK;
			REQ_CREATE: op_in = OP_CREATE;
			REQ_PAUSE:  op_in = OP_PAUSE;
			REQ_RESUME: op_in = OP_RESUME;
			REQ_KILL:   op_in = OP_KILL;
			default:    op_in = OP_NOP;
		endcase
	end

	always_comb begin
		state_d = state_q;
		full = 1'b1;
		cmd_push = 1'b0;
		unique case (state_q)
			FE_IDLE: begin
				full = 1'b0;
				if (push) begin
					state_d = (op_in == OP_CREATE) ? FE_DIV : FE_SEND;
				end
			end
			FE_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = FE_SEND;
				end
			end
			FE_SEND: begin
				cmd_push = 1'b1;
				if (!cmd_full) begin
					state_d = FE_IDLE;
				end
			end
			default: state_d = FE_IDLE;
		endcase
	end

	assign accept = (state_q == FE_IDLE) && push;

	// The low reciprocal half goes in on the first pass, the high half, shifted up,
	// on the second; the quotient is the top of the accumulated product.
	assign quo_in = prod_q[PROD_W-1:PRE_SHIFT];
	assign recip_part = (div_cnt_q == '0) ? RECIP_LO : RECIP_HI;
	assign part = PART_W'(quo_in) * PART_W'(recip_part);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				div_cnt_q <= '0;
			end else if (state_q == FE_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_in;
			idx_q <= item.slot_index;
			rep_q <= item.repeat_flag;
			prod_q <= PROD_W'(item.interval_ms) * PROD_W'(tick_frequency);
		end else if (state_q == FE_DIV) begin
			if (div_cnt_q == '0) begin
				acc_q <= ACC_W'(part);
			end else begin
				acc_q <= acc_q + (ACC_W'(part) << RECIP_HALF);
			end
		end
	end

	assign cmd = '{op: op_q, idx: idx_q, delay: acc_q[RECIP_SHIFT +: DELAY_W], rep: rep_q};

	`ASSERT_NEVER(a_delay_bound, clk, arst_n, cmd_push && op_q == OP_CREATE && PROD_W'(cmd.delay) * PROD_W'(MS_PER_SEC) > prod_q, "create delay exceeds the interval product")

endmodule

[hw/rtl/tess_cmd_queue.sv]
// Short command queue between the front end and the slot sequencer.
`timescale 1ns / 1ps

module tess_cmd_queue import tess_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tess_cmd_t push_data,
	output logic      full,
	input  logic      pop,
	output tess_cmd_t pop_data,
	output logic      valid
);

	tess_cmd_t entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_PTR_W:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
	assign valid = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && valid;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (CMDQ_PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (CMDQ_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/tess_back.sv]
// Back end: slot table, per-slot scan sequencer and result output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tess_back import tess_pkg::*; #(
	parameter int SLOT_COUNT = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  tess_cmd_t cmd,
	output logic      cmd_pop,
	output logic      empty,
	input  logic      pop,
	output tess_out_t result
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

	be_state_t state_q, state_d;
	tess_cmd_t cur_q;
	logic [TICK_W-1:0] now_q;
	logic [SLOT_COUNT-1:0] en_q, rep_q, pau_q, fired_q;
	logic [DELAY_W-1:0] delay_q [SLOT_COUNT];
	logic [TICK_W-1:0] dl_mem [SLOT_COUNT];
	logic [IW-1:0] rd_idx_q;

	logic valid_s1;
	logic [IW-1:0] idx_s1;
	logic [TICK_W-1:0] dl_s1;
	logic valid_s2, en_s2;
	logic [TICK_W-1:0] dl_s2;

	logic [TICK_W-1:0] min_q;
	logic found_q;
	logic placed_q;
	logic [IW-1:0] create_slot_q;

	logic out_valid_q;
	tess_out_t out_q;

	logic new_en, new_rep, new_pau, wr_dl, fire, take_create;
	logic [TICK_W-1:0] new_dl;
	logic [IW-1:0] fire_idx;
	logic fire_single;
	tess_out_t emit_item;
	logic emit_last, out_load, issue;

	// Slot update for the slot whose deadline was read last cycle.
	always_comb begin
		logic [TICK_W-1:0] base;
		logic [DELAY_W-1:0] addend;
		logic [TICK_W-1:0] sum;
		logic idx_hit;
		logic is_free;
		base = (cur_q.op == OP_TICK) ? dl_s1 : now_q;
		addend = (cur_q.op == OP_CREATE) ? cur_q.delay : delay_q[idx_s1];
		sum = base + TICK_W'(addend);
		idx_hit = (32'(cur_q.idx) == 32'(idx_s1));
		is_free = !en_q[idx_s1] && !pau_q[idx_s1] && !rep_q[idx_s1];
		new_en = en_q[idx_s1];
		new_rep = rep_q[idx_s1];
		new_pau = pau_q[idx_s1];
		new_dl = dl_s1;
		wr_dl = 1'b0;
		fire = 1'b0;
		take_create = 1'b0;
		unique case (cur_q.op)
			OP_TICK: begin
				if (en_q[idx_s1] && dl_s1 <= now_q) begin
					fire = 1'b1;
					if (rep_q[idx_s1]) begin
						new_dl = sum;
						wr_dl = 1'b1;
					end else begin
						new_en = 1'b0;
						new_rep = 1'b0;
						new_pau = 1'b0;
					end
				end
			end
			OP_CREATE: begin
				if (!placed_q && idx_s1 != '0 && is_free) begin
					take_create = 1'b1;
					new_dl = sum;
					wr_dl = 1'b1;
					new_en = 1'b1;
					new_rep = cur_q.rep;
					new_pau = 1'b0;
				end
			end
			OP_PAUSE: begin
				if (idx_hit) begin
					new_pau = 1'b1;
					new_en = 1'b0;
				end
			end
			OP_RESUME: begin
				if (idx_hit) begin
					new_dl = sum;
					wr_dl = 1'b1;
					new_en = 1'b1;
					new_pau = 1'b0;
				end
			end
			OP_KILL: begin
				if (idx_hit) begin
					new_en = 1'b0;
					new_rep = 1'b0;
					new_pau = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// Lowest fired slot goes out first.
	always_comb begin
		fire_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (fired_q[i]) begin
				fire_idx = IW'(i);
			end
		end
	end

	assign fire_single = ((fired_q & (fired_q - SLOT_COUNT'(1))) == '0);

	always_comb begin
		emit_item.next_deadline = found_q ? min_q : '0;
		emit_item.result_kind = KIND_DONE;
		emit_item.result_slot = '0;
		emit_item.last_result = 1'b1;
		case (cur_q.op)
			OP_TICK: begin
				if (fired_q != '0) begin
					emit_item.result_kind = KIND_FIRED;
					emit_item.result_slot = 3'(fire_idx);
					emit_item.last_result = fire_single;
				end else begin
					emit_item.result_kind = KIND_NO_FIRE;
				end
			end
			OP_CREATE: begin
				if (placed_q) begin
					emit_item.result_slot = 3'(create_slot_q);
				end else begin
					emit_item.result_kind = KIND_FAIL;
				end
			end
			default: begin
			end
		endcase
		emit_last = emit_item.last_result;
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		issue = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BE_IDLE: begin
				cmd_pop = cmd_valid;
				if (cmd_valid) begin
					state_d = BE_SCAN;
				end
			end
			BE_SCAN: begin
				issue = 1'b1;
				if (rd_idx_q == LAST_SLOT) begin
					state_d = BE_DRAIN;
				end
			end
			BE_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = BE_EMIT;
				end
			end
			BE_EMIT: begin
				out_load = !out_valid_q || pop;
				if (out_load && emit_last) begin
					state_d = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_IDLE;
			now_q <= '0;
			en_q <= '0;
			rep_q <= '0;
			pau_q <= '0;
			fired_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				delay_q[i] <= '0;
			end
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			found_q <= 1'b0;
			placed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (cmd_pop) begin
				if (cmd.op == OP_TICK) begin
					now_q <= now_q + TICK_W'(1);
				end
				rd_idx_q <= '0;
				found_q <= 1'b0;
				placed_q <= 1'b0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (valid_s1) begin
				en_q[idx_s1] <= new_en;
				rep_q[idx_s1] <= new_rep;
				pau_q[idx_s1] <= new_pau;
				if (fire) begin
					fired_q[idx_s1] <= 1'b1;
				end
				if (take_create) begin
					placed_q <= 1'b1;
					delay_q[idx_s1] <= cur_q.delay;
				end
			end
			if (valid_s2 && en_s2 && (!found_q || dl_s2 < min_q)) begin
				found_q <= 1'b1;
			end
			if (out_load && cur_q.op == OP_TICK) begin
				fired_q[fire_idx] <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		idx_s1 <= rd_idx_q;
		en_s2 <= new_en;
		dl_s2 <= new_dl;
		if (valid_s1 && take_create) begin
			create_slot_q <= idx_s1;
		end
		if (valid_s2 && en_s2 && (!found_q || dl_s2 < min_q)) begin
			min_q <= dl_s2;
		end
		if (out_load) begin
			out_q <= emit_item;
		end
	end

	// Deadline memory: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		dl_s1 <= dl_mem[rd_idx_q];
		if (valid_s1 && wr_dl) begin
			dl_mem[idx_s1] <= new_dl;
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	`ASSERT_NEVER(a_create_not_slot0, clk, arst_n, placed_q && create_slot_q == '0, "create handed out the reserved slot")
	`ASSERT_NEVER(a_idle_no_fired, clk, arst_n, state_q == BE_IDLE && fired_q != '0, "fired slots left unreported")

endmodule
